// File: rtl/grom_pkg.sv
// Shared constants for the grid rectangle occupancy map: field widths, opcodes and register indexes.
`default_nettype none
package grom_pkg;

	localparam int OP_W    = 3;
	localparam int COORD_W = 6;
	localparam int DIM_W   = 7;
	localparam int CODE_W  = 2;
	localparam int CNT_W   = 13;
	localparam int CFG_W   = 1;

	localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 3'd0;
	localparam logic [OP_W-1:0] OP_WRITE_CELL = 3'd1;
	localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd2;
	localparam logic [OP_W-1:0] OP_TEST_AREA  = 3'd3;
	localparam logic [OP_W-1:0] OP_MARK_AREA  = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR_AREA = 3'd5;
	localparam logic [OP_W-1:0] OP_COUNT_CODE = 3'd6;

	localparam logic [CFG_W-1:0] REG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_W-1:0] REG_GRID_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] GRID_DIM_RESET = 7'd64;

endpackage
`default_nettype wire

// File: rtl/grom_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module grom_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/grid_rectangle_occupancy_map_core.sv
// Grid occupancy map: one command per beat, cells swept one per cycle through a shared iterator.
// The cell memory, with one write port and one read port, sets the rate: one cell is read or written per cycle.
// A new command is taken only once the previous one has moved into the output register.
// After reset a clearing pass over all MAX_ROWS*MAX_COLS cells empties the store before any beat is taken.
`default_nettype none
module grid_rectangle_occupancy_map_core #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [grom_pkg::CFG_W-1:0]     cfg_index,
	input  wire logic [grom_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [grom_pkg::OP_W-1:0]      opcode,
	input  wire logic [grom_pkg::COORD_W-1:0]   x_coord,
	input  wire logic [grom_pkg::COORD_W-1:0]   y_coord,
	input  wire logic [grom_pkg::DIM_W-1:0]     area_width,
	input  wire logic [grom_pkg::DIM_W-1:0]     area_height,
	input  wire logic [grom_pkg::CODE_W-1:0]    cell_value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                ok,
	output logic [grom_pkg::CODE_W-1:0]         cell_read,
	output logic [grom_pkg::CNT_W-1:0]          match_count
);
	import grom_pkg::*;

	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CALC_W = $clog2(64 * MAX_COLS) + 1;
	localparam int MAXDIM = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int LIMV   = (MAXDIM > 127) ? MAXDIM : 127;
	localparam int LW     = $clog2(LIMV + 1);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [DIM_W-1:0]    grid_width_q;
	logic [DIM_W-1:0]    grid_height_q;
	logic [OP_W-1:0]     op_q;
	logic [CODE_W-1:0]   code_q;
	logic [CODE_W-1:0]   fill_code_q;
	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       row_addr_q;
	logic [AW-1:0]       base_q;
	logic [LW-1:0]       i_q;
	logic [LW-1:0]       j_q;
	logic [LW-1:0]       w_q;
	logic [LW-1:0]       h_q;
	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                rd_vld_s1;
	logic                res_ok_q;
	logic [CODE_W-1:0]   res_rd_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic                out_valid_q;
	logic                ok_q;
	logic [CODE_W-1:0]   cell_read_q;
	logic [CNT_W-1:0]    match_count_q;

	logic [DIM_W-1:0]    cols_use;
	logic [DIM_W-1:0]    rows_use;
	logic                in_grid;
	logic                rect_fits;
	logic                area_empty;
	logic [CALC_W-1:0]   base_wide;
	logic [AW-1:0]       base_addr;
	logic                col_end;
	logic                it_last;
	logic [AW-1:0]       addr_nxt;
	logic [AW-1:0]       row_addr_nxt;
	logic [LW-1:0]       i_nxt;
	logic [LW-1:0]       j_nxt;
	logic                busy_now;
	logic [CNT_W-1:0]    cnt_now;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [CODE_W-1:0]   mem_wdata;
	logic [CODE_W-1:0]   mem_rdata;

	grom_ram #(
		.WIDTH(CODE_W),
		.DEPTH(DEPTH)
	) u_cells (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(addr_q),
		.rdata(mem_rdata)
	);

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != ST_IDLE);
	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign cell_read   = cell_read_q;
	assign match_count = match_count_q;

	always_comb begin
		cols_use   = (9'(grid_width_q) > 9'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_width_q;
		rows_use   = (9'(grid_height_q) > 9'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_height_q;
		in_grid    = (DIM_W'(x_coord) < cols_use) && (DIM_W'(y_coord) < rows_use);
		rect_fits  = ((8'(x_coord) + 8'(area_width)) <= 8'(cols_use)) &&
		             ((8'(y_coord) + 8'(area_height)) <= 8'(rows_use));
		area_empty = (area_width == '0) || (area_height == '0);
		base_wide  = CALC_W'(y_coord) * CALC_W'(MAX_COLS) + CALC_W'(x_coord);
		base_addr  = AW'(base_wide);
	end

	always_comb begin
		col_end = ((i_q + LW'(1)) == w_q);
		it_last = col_end && ((j_q + LW'(1)) == h_q);
		if (col_end) begin
			i_nxt        = '0;
			j_nxt        = j_q + LW'(1);
			row_addr_nxt = row_addr_q + AW'(MAX_COLS);
			addr_nxt     = row_addr_q + AW'(MAX_COLS);
		end else begin
			i_nxt        = i_q + LW'(1);
			j_nxt        = j_q;
			row_addr_nxt = row_addr_q;
			addr_nxt     = addr_q + AW'(1);
		end
	end

	always_comb begin
		busy_now = busy_q | (rd_vld_s1 && (mem_rdata != '0));
		cnt_now  = cnt_q + CNT_W'(rd_vld_s1 && (mem_rdata == code_q));
	end

	always_comb begin
		mem_we    = (state_q == ST_INIT) || (state_q == ST_FILL) ||
		            ((state_q == ST_IDLE) && in_valid && (opcode == OP_WRITE_CELL) && in_grid);
		mem_waddr = (state_q == ST_IDLE) ? base_addr : addr_q;
		mem_wdata = (state_q == ST_IDLE) ? cell_value : fill_code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_DIM_RESET;
			grid_height_q <= GRID_DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT: grid_height_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_INIT;
			op_q          <= OP_CLEAR_ALL;
			code_q        <= '0;
			fill_code_q   <= '0;
			addr_q        <= '0;
			row_addr_q    <= '0;
			base_q        <= '0;
			i_q           <= '0;
			j_q           <= '0;
			w_q           <= LW'(MAX_COLS);
			h_q           <= LW'(MAX_ROWS);
			busy_q        <= 1'b0;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			res_ok_q      <= 1'b0;
			res_rd_q      <= '0;
			res_cnt_q     <= '0;
			out_valid_q   <= 1'b0;
			ok_q          <= 1'b0;
			cell_read_q   <= '0;
			match_count_q <= '0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (rd_vld_s1) begin
				busy_q <= busy_now;
				cnt_q  <= cnt_now;
			end
			unique case (state_q)
				ST_INIT: begin
					addr_q     <= addr_nxt;
					row_addr_q <= row_addr_nxt;
					i_q        <= i_nxt;
					j_q        <= j_nxt;
					if (it_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q        <= opcode;
						code_q      <= cell_value;
						fill_code_q <= cell_value;
						busy_q      <= 1'b0;
						cnt_q       <= '0;
						res_ok_q    <= 1'b0;
						res_rd_q    <= '0;
						res_cnt_q   <= '0;
						addr_q      <= base_addr;
						row_addr_q  <= base_addr;
						base_q      <= base_addr;
						i_q         <= '0;
						j_q         <= '0;
						w_q         <= LW'(area_width);
						h_q         <= LW'(area_height);
						state_q     <= ST_DONE;
						unique case (opcode)
							OP_CLEAR_ALL: begin
								addr_q      <= '0;
								row_addr_q  <= '0;
								base_q      <= '0;
								w_q         <= LW'(MAX_COLS);
								h_q         <= LW'(MAX_ROWS);
								fill_code_q <= '0;
								state_q     <= ST_FILL;
							end
							OP_WRITE_CELL: begin
								res_ok_q <= in_grid;
							end
							OP_READ_CELL: begin
								if (in_grid) begin
									w_q     <= LW'(1);
									h_q     <= LW'(1);
									state_q <= ST_SCAN;
								end
							end
							OP_TEST_AREA, OP_MARK_AREA: begin
								if (rect_fits && area_empty) begin
									res_ok_q <= 1'b1;
								end else if (rect_fits) begin
									state_q <= ST_SCAN;
								end
							end
							OP_CLEAR_AREA: begin
								fill_code_q <= '0;
								if (rect_fits && area_empty) begin
									res_ok_q <= 1'b1;
								end else if (rect_fits) begin
									state_q <= ST_FILL;
								end
							end
							OP_COUNT_CODE: begin
								addr_q     <= '0;
								row_addr_q <= '0;
								base_q     <= '0;
								w_q        <= LW'(cols_use);
								h_q        <= LW'(rows_use);
								if ((cols_use == '0) || (rows_use == '0)) begin
									res_ok_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_s1  <= 1'b1;
					addr_q     <= addr_nxt;
					row_addr_q <= row_addr_nxt;
					i_q        <= i_nxt;
					j_q        <= j_nxt;
					if (it_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
					unique case (op_q)
						OP_READ_CELL: begin
							res_ok_q <= 1'b1;
							res_rd_q <= mem_rdata;
						end
						OP_TEST_AREA: begin
							res_ok_q <= !busy_now;
						end
						OP_MARK_AREA: begin
							if (!busy_now) begin
								addr_q     <= base_q;
								row_addr_q <= base_q;
								i_q        <= '0;
								j_q        <= '0;
								state_q    <= ST_FILL;
							end
						end
						OP_COUNT_CODE: begin
							res_ok_q  <= 1'b1;
							res_cnt_q <= cnt_now;
						end
						default: begin
						end
					endcase
				end
				ST_FILL: begin
					addr_q     <= addr_nxt;
					row_addr_q <= row_addr_nxt;
					i_q        <= i_nxt;
					j_q        <= j_nxt;
					if (it_last) begin
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						ok_q          <= res_ok_q;
						cell_read_q   <= res_rd_q;
						match_count_q <= res_cnt_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_iter_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_SCAN) || (state_q == ST_FILL) || (state_q == ST_INIT))
		|-> ((i_q < w_q) && (j_q < h_q)))
		else $error("Sweep position left the rectangle.");

	a_mark_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FILL) && (op_q == OP_MARK_AREA)) |-> !busy_q)
		else $error("Mark fill started on an occupied rectangle.");

	a_no_result_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !out_valid_q)
		else $error("Result beat shown during the clearing pass.");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && !out_valid_q) |=> (out_valid_q && (state_q == ST_IDLE)))
		else $error("Finished result not moved into the output register.");

endmodule
`default_nettype wire
